### hw/rtl/kst_pkg.sv
package kst_pkg;

   localparam int DATA_WIDTH_DEF   = 32;
   localparam int FRAC_BITS_DEF    = 16;
   localparam int DT_FRAC_BITS_DEF = 24;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int IO_WIDTH        = 32;
   localparam int OP_WIDTH        = 2;
   localparam int DT_WIDTH        = 24;
   localparam int NOISE_WIDTH     = 31;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DT_STEP      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Q_SPEED      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Q_ACCEL      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_R_MEAS       = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INIT_SPEED   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_P_INIT_SPEED = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_P_INIT_ACCEL = 3'd6;

   localparam logic [OP_WIDTH-1:0] OP_UPDATE = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_LOAD   = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_CLEAR  = 2'd2;

   localparam logic [DT_WIDTH-1:0]    DT_STEP_RST      = 24'd8389;
   localparam logic [NOISE_WIDTH-1:0] Q_SPEED_RST      = 31'd6554;
   localparam logic [NOISE_WIDTH-1:0] Q_ACCEL_RST      = 31'd655360;
   localparam logic [NOISE_WIDTH-1:0] R_MEAS_RST       = 31'd983040;
   localparam logic [IO_WIDTH-1:0]    INIT_SPEED_RST   = 32'd0;
   localparam logic [NOISE_WIDTH-1:0] P_INIT_SPEED_RST = 31'd65536;
   localparam logic [NOISE_WIDTH-1:0] P_INIT_ACCEL_RST = 31'd196608000;

   localparam longint CLEAR_VAR_INT = 1000;

   localparam int STEP_WIDTH = 5;
   localparam logic [STEP_WIDTH-1:0] LAST_STEP = 5'd16;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ISSUE = 5'b00010,
      ST_ACC   = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      K_MUL,
      K_ADD,
      K_DIV
   } kind_type;

   typedef enum logic [4:0] {
      D_XP0, D_FP00, D_PP01, D_U, D_PP00, D_PP10, D_PP11, D_Y, D_S,
      D_K0, D_K1, D_XS, D_XA, D_C00, D_C01, D_C10, D_C11
   } dst_type;

endpackage

### hw/rtl/kst_mul.sv
module kst_mul #(
   parameter int DATA_WIDTH = kst_pkg::DATA_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [DATA_WIDTH:0]    op_a,
   input  logic signed [DATA_WIDTH:0]    op_b,
   output logic [2*DATA_WIDTH-1:0]       prod_ff,
   output logic                          neg_ff
);
   logic signed [DATA_WIDTH:0] abs_a, abs_b;

   always_comb begin
      abs_a = op_a[DATA_WIDTH] ? -op_a : op_a;
      abs_b = op_b[DATA_WIDTH] ? -op_b : op_b;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= abs_a[DATA_WIDTH-1:0] * abs_b[DATA_WIDTH-1:0];
         neg_ff  <= op_a[DATA_WIDTH] ^ op_b[DATA_WIDTH];
      end
   end
endmodule

### hw/rtl/kst_div.sv
module kst_div #(
   parameter int DATA_WIDTH = kst_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = kst_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [DATA_WIDTH-1:0] num,
   input  logic signed [DATA_WIDTH-1:0] den,
   output logic                         done_ff,
   output logic signed [DATA_WIDTH-1:0] quot,
   output logic                         quot_sat
);
   localparam int N  = DATA_WIDTH + FRAC_BITS;
   localparam int CW = $clog2(N + 1);

   logic [N-1:0]            dvd_ff, q_ff;
   logic [DATA_WIDTH-1:0]   rem_ff, den_ff;
   logic [CW-1:0]           cnt_ff;
   logic                    busy_ff, neg_ff;
   logic signed [DATA_WIDTH:0] num_x, den_x, abs_n, abs_d;
   logic [DATA_WIDTH:0]     r2;
   logic [N-1:0]            lim;

   always_comb begin
      num_x = {num[DATA_WIDTH-1], num};
      den_x = {den[DATA_WIDTH-1], den};
      abs_n = num_x[DATA_WIDTH] ? -num_x : num_x;
      abs_d = den_x[DATA_WIDTH] ? -den_x : den_x;
      r2    = {rem_ff, dvd_ff[N-1]};
      lim   = N'({1'b1, {(DATA_WIDTH-1){1'b0}}}) - N'(!neg_ff);
      if (q_ff > lim) begin
         quot     = neg_ff ? DATA_WIDTH'(-$signed({1'b0, lim})) : lim[DATA_WIDTH-1:0];
         quot_sat = 1'b1;
      end else begin
         quot     = neg_ff ? DATA_WIDTH'(-$signed({1'b0, q_ff})) : q_ff[DATA_WIDTH-1:0];
         quot_sat = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(N);
            dvd_ff  <= {abs_n[DATA_WIDTH-1:0], {FRAC_BITS{1'b0}}};
            rem_ff  <= '0;
            q_ff    <= '0;
            den_ff  <= abs_d[DATA_WIDTH-1:0];
            neg_ff  <= num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
         end else if (busy_ff) begin
            dvd_ff <= {dvd_ff[N-2:0], 1'b0};
            if (r2 >= {1'b0, den_ff}) begin
               rem_ff <= DATA_WIDTH'(r2 - {1'b0, den_ff});
               q_ff   <= {q_ff[N-2:0], 1'b1};
            end else begin
               rem_ff <= r2[DATA_WIDTH-1:0];
               q_ff   <= {q_ff[N-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule

### hw/rtl/kalman_speed_accel_tracker_top.sv
// channel | ports                                   | beat
// req     | req_valid req_ready req_op req_speed_meas | one command
// rsp     | rsp_valid rsp_ready rsp_speed_est ...     | one estimate
// csr     | csr_we csr_index csr_wdata                | one register write
// An update beat runs 17 micro-steps on the shared multiplier/saturating adder,
// the two gains one quotient bit a cycle in the divider (on the multiplier
// when the innovation variance is zero). Load, clear and spare ops skip the steps.
// Synchronous reset reloads registers and state. One beat in flight; a stalled
// result holds and a new beat is still taken once the sequencer is idle.
module kalman_speed_accel_tracker_top #(
   parameter int DATA_WIDTH   = kst_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS    = kst_pkg::FRAC_BITS_DEF,
   parameter int DT_FRAC_BITS = kst_pkg::DT_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [kst_pkg::OP_WIDTH-1:0]          req_op,
   input  logic signed [kst_pkg::IO_WIDTH-1:0]   req_speed_meas,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [kst_pkg::IO_WIDTH-1:0]   rsp_speed_est,
   output logic signed [kst_pkg::IO_WIDTH-1:0]   rsp_accel_est,
   output logic                                  rsp_saturated,
   input  logic                                  csr_we,
   input  logic [kst_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [kst_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import kst_pkg::*;

   localparam int W = DATA_WIDTH;
   localparam logic signed [63:0] VMAX = (64'sd1 <<< (W-1)) - 64'sd1;
   localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;
   localparam logic signed [63:0] BIG_RAW = 64'(CLEAR_VAR_INT) <<< FRAC_BITS;

   function automatic logic [W:0] sat64(input logic signed [63:0] v);
      if (v > VMAX) return {1'b1, VMAX[W-1:0]};
      if (v < VMIN) return {1'b1, VMIN[W-1:0]};
      return {1'b0, v[W-1:0]};
   endfunction

   function automatic logic signed [W:0] ext(input logic signed [W-1:0] v);
      return {v[W-1], v};
   endfunction

   localparam logic [W:0] C00_RST = sat64(64'({33'd0, P_INIT_SPEED_RST}));
   localparam logic [W:0] C11_RST = sat64(64'({33'd0, P_INIT_ACCEL_RST}));

   logic [DT_WIDTH-1:0]    dt_ff;
   logic [NOISE_WIDTH-1:0] qs_ff, qa_ff, r_ff, pis_ff, pia_ff;
   logic [IO_WIDTH-1:0]    ispd_ff;

   logic signed [W-1:0] xs_ff, xa_ff, c00_ff, c01_ff, c10_ff, c11_ff;
   logic signed [W-1:0] xp0_ff, fp00_ff, pp01_ff, u_ff, pp00_ff, pp10_ff, pp11_ff;
   logic signed [W-1:0] y_ff, s_ff, k0_ff, k1_ff, z_ff;
   logic                sat_ff;

   state_type            state_ff, state_in;
   logic [STEP_WIDTH-1:0] step_ff;

   logic rsp_valid_ff, rsp_sat_ff;
   logic signed [IO_WIDTH-1:0] rsp_speed_ff, rsp_accel_ff;

   logic [W:0] s_qs, s_qa, s_r, s_pis, s_pia, s_isp, s_z, s_big, s_sum;
   logic signed [W:0]   op_a, op_b, dtw, term;
   logic signed [W-1:0] op_c, op_d, wb_val;
   logic                sub, sh_dt, mul_en, div_start, wb_en, wb_flag, accept, cflag;
   kind_type            kind;
   dst_type             dst;

   logic [2*W-1:0] prod_ff, shifted, lim;
   logic           pneg_ff, tsat;
   logic signed [W+1:0] sum;
   logic           div_done;
   logic signed [W-1:0] div_q;
   logic           div_sat;
   logic signed [63:0] xs64, xa64;

   kst_mul #(.DATA_WIDTH(W)) u_mul (
      .clock(clock), .en(mul_en), .op_a(op_a), .op_b(op_b),
      .prod_ff(prod_ff), .neg_ff(pneg_ff)
   );

   kst_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(op_a[W-1:0]),
      .den(s_ff), .done_ff(div_done), .quot(div_q), .quot_sat(div_sat)
   );

   always_comb begin
      s_qs  = sat64(64'({33'd0, qs_ff}));
      s_qa  = sat64(64'({33'd0, qa_ff}));
      s_r   = sat64(64'({33'd0, r_ff}));
      s_pis = sat64(64'({33'd0, pis_ff}));
      s_pia = sat64(64'({33'd0, pia_ff}));
      s_isp = sat64(64'($signed(ispd_ff)));
      s_z   = sat64(64'(req_speed_meas));
      s_big = sat64(BIG_RAW);
      dtw   = $signed({{(W+1-DT_WIDTH){1'b0}}, dt_ff});
   end

   always_comb begin
      op_a = dtw; op_b = ext(xa_ff); op_c = xs_ff; op_d = '0;
      sub = 1'b0; sh_dt = 1'b1; kind = K_MUL; dst = D_XP0; cflag = 1'b0;
      unique case (step_ff)
         5'd0: begin op_b = ext(xa_ff); op_c = xs_ff; dst = D_XP0; end
         5'd1: begin op_b = ext(c10_ff); op_c = c00_ff; dst = D_FP00; end
         5'd2: begin op_b = ext(c11_ff); op_c = c01_ff; dst = D_PP01; end
         5'd3: begin op_a = ext(pp01_ff); op_b = dtw; op_c = fp00_ff; dst = D_U; end
         5'd4: begin
            kind = K_ADD; op_c = u_ff; op_d = s_qs[W-1:0]; cflag = s_qs[W]; dst = D_PP00;
         end
         5'd5: begin op_a = ext(c11_ff); op_b = dtw; op_c = c10_ff; dst = D_PP10; end
         5'd6: begin
            kind = K_ADD; op_c = c11_ff; op_d = s_qa[W-1:0]; cflag = s_qa[W]; dst = D_PP11;
         end
         5'd7: begin kind = K_ADD; sub = 1'b1; op_c = z_ff; op_d = xp0_ff; dst = D_Y; end
         5'd8: begin
            kind = K_ADD; op_c = pp00_ff; op_d = s_r[W-1:0]; cflag = s_r[W]; dst = D_S;
         end
         5'd9: begin
            kind = K_DIV; sh_dt = 1'b0; op_a = ext(pp00_ff);
            op_b = ext(VMAX[W-1:0]); op_c = '0; dst = D_K0;
         end
         5'd10: begin
            kind = K_DIV; sh_dt = 1'b0; op_a = ext(pp10_ff);
            op_b = ext(VMAX[W-1:0]); op_c = '0; dst = D_K1;
         end
         5'd11: begin
            sh_dt = 1'b0; op_a = ext(k0_ff); op_b = ext(y_ff); op_c = xp0_ff; dst = D_XS;
         end
         5'd12: begin
            sh_dt = 1'b0; op_a = ext(k1_ff); op_b = ext(y_ff); op_c = xa_ff; dst = D_XA;
         end
         5'd13: begin
            sh_dt = 1'b0; sub = 1'b1; op_a = ext(k0_ff); op_b = ext(pp00_ff);
            op_c = pp00_ff; dst = D_C00;
         end
         5'd14: begin
            sh_dt = 1'b0; sub = 1'b1; op_a = ext(k0_ff); op_b = ext(pp01_ff);
            op_c = pp01_ff; dst = D_C01;
         end
         5'd15: begin
            sh_dt = 1'b0; sub = 1'b1; op_a = ext(k1_ff); op_b = ext(pp00_ff);
            op_c = pp10_ff; dst = D_C10;
         end
         5'd16: begin
            sh_dt = 1'b0; sub = 1'b1; op_a = ext(k1_ff); op_b = ext(pp01_ff);
            op_c = pp11_ff; dst = D_C11;
         end
         default: begin end
      endcase
   end

   // product rescale and saturating accumulate
   always_comb begin
      shifted = sh_dt ? (prod_ff >> DT_FRAC_BITS) : (prod_ff >> FRAC_BITS);
      lim     = (2*W)'({1'b1, {(W-1){1'b0}}}) - (2*W)'(!pneg_ff);
      tsat    = 1'b0;
      if (kind == K_ADD) begin
         term = ext(op_d);
      end else if (shifted > lim) begin
         tsat = 1'b1;
         term = pneg_ff ? -$signed({1'b0, lim[W-1:0]}) : $signed({1'b0, lim[W-1:0]});
      end else begin
         term = pneg_ff ? -$signed({1'b0, shifted[W-1:0]})
                        : $signed({1'b0, shifted[W-1:0]});
      end
      sum   = sub ? ({op_c[W-1], op_c[W-1], op_c} - {term[W], term})
                  : ({op_c[W-1], op_c[W-1], op_c} + {term[W], term});
      s_sum = sat64(64'(sum));
   end

   always_comb begin
      req_ready = state_ff == ST_IDLE;
      accept    = req_valid && req_ready;
      state_in  = state_ff;
      mul_en    = 1'b0;
      div_start = 1'b0;
      wb_en     = 1'b0;
      wb_val    = s_sum[W-1:0];
      wb_flag   = tsat | s_sum[W] | cflag;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = (req_op == OP_UPDATE) ? ST_ISSUE : ST_OUT;
         ST_ISSUE: begin
            if (kind == K_DIV && s_ff != '0) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               mul_en   = kind != K_ADD;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            wb_en    = 1'b1;
            state_in = (step_ff == LAST_STEP) ? ST_OUT : ST_ISSUE;
         end
         ST_DIV: begin
            if (div_done) begin
               wb_en    = 1'b1;
               wb_val   = div_q;
               wb_flag  = div_sat;
               state_in = ST_ISSUE;
            end
         end
         ST_OUT: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff   <= DT_STEP_RST;
         qs_ff   <= Q_SPEED_RST;
         qa_ff   <= Q_ACCEL_RST;
         r_ff    <= R_MEAS_RST;
         ispd_ff <= INIT_SPEED_RST;
         pis_ff  <= P_INIT_SPEED_RST;
         pia_ff  <= P_INIT_ACCEL_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DT_STEP:      dt_ff   <= csr_wdata[DT_WIDTH-1:0];
            CSR_Q_SPEED:      qs_ff   <= csr_wdata[NOISE_WIDTH-1:0];
            CSR_Q_ACCEL:      qa_ff   <= csr_wdata[NOISE_WIDTH-1:0];
            CSR_R_MEAS:       r_ff    <= csr_wdata[NOISE_WIDTH-1:0];
            CSR_INIT_SPEED:   ispd_ff <= csr_wdata;
            CSR_P_INIT_SPEED: pis_ff  <= csr_wdata[NOISE_WIDTH-1:0];
            CSR_P_INIT_ACCEL: pia_ff  <= csr_wdata[NOISE_WIDTH-1:0];
            default: begin end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         xs_ff    <= '0;
         xa_ff    <= '0;
         c00_ff   <= C00_RST[W-1:0];
         c11_ff   <= C11_RST[W-1:0];
         c01_ff   <= '0;
         c10_ff   <= '0;
         sat_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            step_ff <= '0;
            z_ff    <= s_z[W-1:0];
            unique case (req_op)
               OP_UPDATE: sat_ff <= s_z[W];
               OP_LOAD: begin
                  xs_ff  <= s_isp[W-1:0];
                  xa_ff  <= '0;
                  c00_ff <= s_pis[W-1:0];
                  c11_ff <= s_pia[W-1:0];
                  c01_ff <= '0;
                  c10_ff <= '0;
                  sat_ff <= s_isp[W] | s_pis[W] | s_pia[W];
               end
               OP_CLEAR: begin
                  xs_ff  <= '0;
                  xa_ff  <= '0;
                  c00_ff <= s_big[W-1:0];
                  c11_ff <= s_big[W-1:0];
                  c01_ff <= '0;
                  c10_ff <= '0;
                  sat_ff <= s_big[W];
               end
               default: sat_ff <= 1'b0;
            endcase
         end
         if (wb_en) begin
            step_ff <= step_ff + 1'b1;
            sat_ff  <= sat_ff | wb_flag;
            unique case (dst)
               D_XP0:  xp0_ff  <= wb_val;
               D_FP00: fp00_ff <= wb_val;
               D_PP01: pp01_ff <= wb_val;
               D_U:    u_ff    <= wb_val;
               D_PP00: pp00_ff <= wb_val;
               D_PP10: pp10_ff <= wb_val;
               D_PP11: pp11_ff <= wb_val;
               D_Y:    y_ff    <= wb_val;
               D_S:    s_ff    <= wb_val;
               D_K0:   k0_ff   <= wb_val;
               D_K1:   k1_ff   <= wb_val;
               D_XS:   xs_ff   <= wb_val;
               D_XA:   xa_ff   <= wb_val;
               D_C00:  c00_ff  <= wb_val;
               D_C01:  c01_ff  <= wb_val;
               D_C10:  c10_ff  <= wb_val;
               D_C11:  c11_ff  <= wb_val;
               default: begin end
            endcase
         end
      end
   end

   always_comb begin
      xs64 = 64'(xs_ff);
      xa64 = 64'(xa_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_ff <= 1'b1;
         rsp_speed_ff <= xs64[IO_WIDTH-1:0];
         rsp_accel_ff <= xa64[IO_WIDTH-1:0];
         rsp_sat_ff   <= sat_ff;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_speed_est = rsp_speed_ff;
   assign rsp_accel_est = rsp_accel_ff;
   assign rsp_saturated = rsp_sat_ff;
endmodule

### hw/rtl/kst_checker.sv
module kst_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [kst_pkg::IO_WIDTH-1:0] rsp_speed_est,
   input logic signed [kst_pkg::IO_WIDTH-1:0] rsp_accel_est
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_speed_est) && $stable(rsp_accel_est))
      else $error("result beat changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second command taken while one is in flight");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_ready && !rsp_valid)
      else $error("block not idle after reset");
endmodule

bind kalman_speed_accel_tracker_top kst_checker u_kst_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_speed_est(rsp_speed_est), .rsp_accel_est(rsp_accel_est)
);

### dv/tb_kalman_speed_accel_tracker_top.sv
module tb_kalman_speed_accel_tracker_top;
   timeunit 1ns;
   timeprecision 1ps;
   import kst_pkg::*;

   localparam logic [OP_WIDTH-1:0] OP_SPARE = 2'd3;
   localparam longint VMAX = 64'sd2147483647;
   localparam longint VMIN = -64'sd2147483648;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct {
      logic [OP_WIDTH-1:0]        op;
      logic signed [IO_WIDTH-1:0] meas;
   } cmd_type;

   typedef struct {
      logic signed [IO_WIDTH-1:0] spd;
      logic signed [IO_WIDTH-1:0] acc;
      bit                         sat;
   } est_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [OP_WIDTH-1:0] req_op = '0;
   logic signed [IO_WIDTH-1:0] req_speed_meas = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [IO_WIDTH-1:0] rsp_speed_est;
   logic signed [IO_WIDTH-1:0] rsp_accel_est;
   logic rsp_saturated;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   cmd_type cmd_q[$];
   est_type est_q[$];
   bit   req_fire = 0;
   int   n_in = 0, n_out = 0, n_sat = 0, n_bad = 0, quiet = 0, hold_left = 0;
   int   n_op[4] = '{0, 0, 0, 0};
   bit   held = 0;

   // filter state and register copies
   longint cfg_dt, cfg_qs, cfg_qa, cfg_r, cfg_x0, cfg_p0s, cfg_p0a;
   longint x_spd, x_acc, p00, p01, p10, p11;

   kalman_speed_accel_tracker_top uut (.*);

   always #5 clock = ~clock;

   function automatic longint clip(longint v, inout bit f);
      if (v > VMAX) begin
         f = 1;
         return VMAX;
      end
      if (v < VMIN) begin
         f = 1;
         return VMIN;
      end
      return v;
   endfunction

   function automatic logic [127:0] mag(longint v);
      logic [63:0] u;
      u = v < 0 ? -v : v;
      return {64'd0, u};
   endfunction

   function automatic longint from_mag(logic [127:0] m, bit neg, inout bit f);
      logic [127:0] lim;
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (m > lim) begin
         f = 1;
         m = lim;
      end
      return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
   endfunction

   function automatic longint mul_trunc(longint a, longint b, int sh, inout bit f);
      logic [127:0] m;
      m = (mag(a) * mag(b)) >> sh;
      return from_mag(m, (a < 0) != (b < 0), f);
   endfunction

   function automatic longint gain_div(longint num, longint den, inout bit f);
      if (den == 0) return mul_trunc(num, VMAX, FRAC_BITS_DEF, f);
      return from_mag((mag(num) << FRAC_BITS_DEF) / mag(den), (num < 0) != (den < 0), f);
   endfunction

   function automatic void load_state(inout bit f);
      x_spd = clip(cfg_x0, f);
      x_acc = 0;
      p00 = clip(cfg_p0s, f);
      p11 = clip(cfg_p0a, f);
      p01 = 0;
      p10 = 0;
   endfunction

   function automatic est_type kalman_step(cmd_type c);
      est_type e;
      bit f;
      longint z, xp0, xp1, fp00, fp01, pp00, pp01, pp10, pp11, y, s, k0, k1, big;
      f = 0;
      if (c.op == OP_UPDATE) begin
         z = longint'(c.meas);
         xp0 = clip(x_spd + mul_trunc(cfg_dt, x_acc, DT_FRAC_BITS_DEF, f), f);
         xp1 = x_acc;
         fp00 = clip(p00 + mul_trunc(cfg_dt, p10, DT_FRAC_BITS_DEF, f), f);
         fp01 = clip(p01 + mul_trunc(cfg_dt, p11, DT_FRAC_BITS_DEF, f), f);
         pp00 = clip(clip(fp00 + mul_trunc(fp01, cfg_dt, DT_FRAC_BITS_DEF, f), f)
                     + clip(cfg_qs, f), f);
         pp01 = fp01;
         pp10 = clip(p10 + mul_trunc(p11, cfg_dt, DT_FRAC_BITS_DEF, f), f);
         pp11 = clip(p11 + clip(cfg_qa, f), f);
         y = clip(z - xp0, f);
         s = clip(pp00 + clip(cfg_r, f), f);
         k0 = gain_div(pp00, s, f);
         k1 = gain_div(pp10, s, f);
         x_spd = clip(xp0 + mul_trunc(k0, y, FRAC_BITS_DEF, f), f);
         x_acc = clip(xp1 + mul_trunc(k1, y, FRAC_BITS_DEF, f), f);
         p00 = clip(pp00 - mul_trunc(k0, pp00, FRAC_BITS_DEF, f), f);
         p01 = clip(pp01 - mul_trunc(k0, pp01, FRAC_BITS_DEF, f), f);
         p10 = clip(pp10 - mul_trunc(k1, pp00, FRAC_BITS_DEF, f), f);
         p11 = clip(pp11 - mul_trunc(k1, pp01, FRAC_BITS_DEF, f), f);
      end else if (c.op == OP_LOAD) begin
         load_state(f);
      end else if (c.op == OP_CLEAR) begin
         big = clip(CLEAR_VAR_INT << FRAC_BITS_DEF, f);
         x_spd = 0;
         x_acc = 0;
         p00 = big;
         p11 = big;
         p01 = 0;
         p10 = 0;
      end
      e.spd = x_spd[31:0];
      e.acc = x_acc[31:0];
      e.sat = f;
      return e;
   endfunction

   function automatic bit idling();
      return !(n_in >= 500 && n_in < 750) && $urandom_range(99) < 23;
   endfunction

   // sender
   always @(negedge clock) begin
      cmd_type c;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (cmd_q.size() > 0 && !idling()) begin
            c = cmd_q.pop_front();
            req_valid <= 1'b1;
            req_op <= c.op;
            req_speed_meas <= c.meas;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off so the block backs up
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (n_in >= 300 && !held) begin
         held <= 1;
         hold_left <= 600;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !idling();
      end
   end

   // beat capture, prediction and compare
   always @(posedge clock) begin
      cmd_type c;
      est_type e;
      bit      busy;
      req_fire <= req_valid && req_ready && !reset;
      if (!reset) begin
         busy = (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we;
         quiet <= busy ? 0 : quiet + 1;
         if (req_valid && req_ready) begin
            c.op = req_op;
            c.meas = req_speed_meas;
            est_q.push_back(kalman_step(c));
            n_in <= n_in + 1;
            n_op[req_op] <= n_op[req_op] + 1;
         end
         if (rsp_valid && rsp_ready) begin
            n_out <= n_out + 1;
            if (est_q.size() == 0) begin
               n_bad <= n_bad + 1;
               if (n_bad < 10) $display("unexpected estimate beat");
            end else begin
               e = est_q.pop_front();
               if (e.sat) n_sat <= n_sat + 1;
               if (rsp_speed_est !== e.spd || rsp_accel_est !== e.acc
                   || rsp_saturated !== e.sat) begin
                  n_bad <= n_bad + 1;
                  if (n_bad < 10)
                     $display("beat %0d: exp spd %0d acc %0d sat %0b, got %0d %0d %0b",
                              n_out, e.spd, e.acc, e.sat, rsp_speed_est,
                              rsp_accel_est, rsp_saturated);
               end
            end
         end
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   task automatic add_cmd(logic [OP_WIDTH-1:0] op, logic signed [IO_WIDTH-1:0] meas);
      cmd_type c;
      c.op = op;
      c.meas = meas;
      cmd_q.push_back(c);
   endtask

   task automatic drain();
      while (cmd_q.size() > 0 || req_valid || est_q.size() > 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_DT_STEP:      cfg_dt = val[23:0];
         CSR_Q_SPEED:      cfg_qs = val[30:0];
         CSR_Q_ACCEL:      cfg_qa = val[30:0];
         CSR_R_MEAS:       cfg_r = val[30:0];
         CSR_INIT_SPEED:   cfg_x0 = longint'($signed(val));
         CSR_P_INIT_SPEED: cfg_p0s = val[30:0];
         CSR_P_INIT_ACCEL: cfg_p0a = val[30:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_all(logic [31:0] dt, logic [31:0] qs, logic [31:0] qa, logic [31:0] r,
                          logic [31:0] x0, logic [31:0] ps, logic [31:0] pa);
      csr_write(CSR_DT_STEP, dt);
      csr_write(CSR_Q_SPEED, qs);
      csr_write(CSR_Q_ACCEL, qa);
      csr_write(CSR_R_MEAS, r);
      csr_write(CSR_INIT_SPEED, x0);
      csr_write(CSR_P_INIT_SPEED, ps);
      csr_write(CSR_P_INIT_ACCEL, pa);
   endtask

   function automatic logic [31:0] rnd_meas(logic signed [31:0] near);
      case ($urandom_range(9))
         0, 1:    return $urandom;
         2:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return near + $signed($urandom_range(2 * 655360) - 655360);
      endcase
   endfunction

   initial begin
      logic signed [31:0] trk;
      cfg_dt = DT_STEP_RST;
      cfg_qs = Q_SPEED_RST;
      cfg_qa = Q_ACCEL_RST;
      cfg_r = R_MEAS_RST;
      cfg_x0 = longint'($signed(INIT_SPEED_RST));
      cfg_p0s = P_INIT_SPEED_RST;
      cfg_p0a = P_INIT_ACCEL_RST;
      begin
         bit f;
         load_state(f);
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: fields at extremes, every op, spare op, clear, load
      add_cmd(OP_UPDATE, 32'sd0);
      add_cmd(OP_UPDATE, 32'sh7fff_ffff);
      add_cmd(OP_UPDATE, 32'sh8000_0000);
      add_cmd(OP_UPDATE, -32'sd1);
      add_cmd(OP_SPARE, 32'sh5a5a_a5a5);
      add_cmd(OP_CLEAR, 32'sh7fff_ffff);
      add_cmd(OP_UPDATE, 32'sd655360);
      add_cmd(OP_UPDATE, 32'sd720896);
      add_cmd(OP_LOAD, 32'sh8000_0000);
      add_cmd(OP_UPDATE, 32'sd65536);
      add_cmd(OP_SPARE, 32'sd0);
      drain();

      // zero innovation variance: no noise, zero initial variances
      set_all(32'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000, 32'd0, 32'd0);
      add_cmd(OP_LOAD, 32'sd0);
      add_cmd(OP_UPDATE, 32'sd0);
      add_cmd(OP_UPDATE, 32'sd100);
      add_cmd(OP_UPDATE, -32'sd65536);
      drain();

      // saturating extremes
      set_all(32'h00ff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      add_cmd(OP_LOAD, 32'sd0);
      add_cmd(OP_UPDATE, 32'sh8000_0000);
      add_cmd(OP_UPDATE, 32'sh7fff_ffff);
      add_cmd(OP_CLEAR, 32'sd0);
      add_cmd(OP_UPDATE, 32'sh8000_0000);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_all(DT_STEP_RST, Q_SPEED_RST, Q_ACCEL_RST, R_MEAS_RST,
                       INIT_SPEED_RST, P_INIT_SPEED_RST, P_INIT_ACCEL_RST);
            1: set_all(32'h00ff_ffff, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0);
            2: set_all(32'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                       32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
            default: set_all($urandom_range(24'hff_ffff), $urandom_range(32'h0010_0000),
                             $urandom_range(32'h0100_0000), $urandom_range(32'h0100_0000),
                             $urandom, $urandom, $urandom);
         endcase
         add_cmd(OP_LOAD, $urandom);
         trk = $urandom_range(1 << 22);
         for (int i = 0; i < 190; i++) begin
            case ($urandom_range(39))
               0:       add_cmd(OP_LOAD, $urandom);
               1:       add_cmd(OP_CLEAR, $urandom);
               2:       add_cmd(OP_SPARE, $urandom);
               default: begin
                  trk = trk + $signed($urandom_range(131072) - 65536);
                  add_cmd(OP_UPDATE, rnd_meas(trk));
               end
            endcase
            if (ph == 3 && i == 95) drain();
         end
         drain();
      end

      drain();
      $display("%0d commands (update %0d, load %0d, clear %0d, spare %0d), %0d estimates",
               n_in, n_op[0], n_op[1], n_op[2], n_op[3], n_out);
      $display("%0d steps clipped, 6 register sets plus zero-variance and saturation sets",
               n_sat);
      if (n_bad == 0 && est_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

### kalman_speed_accel_tracker_top.f
hw/rtl/kst_pkg.sv
hw/rtl/kst_mul.sv
hw/rtl/kst_div.sv
hw/rtl/kalman_speed_accel_tracker_top.sv
hw/rtl/kst_checker.sv
dv/tb_kalman_speed_accel_tracker_top.sv
